FILE: hw/rtl/fdr_pkg.sv
// Shared types, widths and codes of the gamma LED fader.
`default_nettype none
package fdr_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam logic [2:0] DEF_GAMMA = 3'd3;

  // Stream widths
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD     = 4;

  // Item kinds carried in in_tuser
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_STOP  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_TICK  = 2'd3;

  // Arithmetic widths: v^7 < 2^56, 255^6 < 2^48
  localparam int NUM_W = 56;
  localparam int DEN_W = 48;
  localparam int DVD_W = 58;
  localparam int DVS_W = 49;
  localparam int Q_W   = 8;

  typedef enum logic {
    AR_GAMMA,
    AR_DIV
  } ar_op_t;

  // One channel table entry
  typedef struct packed {
    logic [2:0]  gam;
    logic [31:0] dur;
    logic [31:0] st;
    logic [7:0]  cur;
    logic [7:0]  start;
    logic [7:0]  tgt;
    logic [7:0]  pin;
  } chan_t;

  localparam chan_t CHAN_RESET = '{gam: DEF_GAMMA, dur: 32'd0, st: 32'd0, cur: 8'd0,
                                   start: 8'd0, tgt: 8'd0, pin: 8'd0};

  // One result; pin lands in the lowest bits
  typedef struct packed {
    logic [7:0] cur;
    logic       act;
    logic       ok;
    logic [7:0] dl;
    logic       dv;
    logic [7:0] wl;
    logic       wv;
    logic [7:0] pin;
  } res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/fdr_mem.sv
// Channel table memory with per-entry written flags.
`default_nettype none
module fdr_mem #(
  parameter int DEPTH = fdr_pkg::NUM_CHANNELS_DEF,
  parameter int AW    = 3
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output fdr_pkg::chan_t       rd_data,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire fdr_pkg::chan_t  wr_data
);

  fdr_pkg::chan_t mem [DEPTH];
  logic [DEPTH-1:0] wrt_r;
  fdr_pkg::chan_t rd_q_r;
  logic rd_w_r;

  // storage and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // written flags; unwritten entries read as reset contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrt_r  <= '0;
      rd_w_r <= 1'b0;
    end else begin
      if (wr_en) begin
        wrt_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_w_r <= wrt_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_w_r ? rd_q_r : fdr_pkg::CHAN_RESET;

endmodule
`default_nettype wire

FILE: hw/rtl/fdr_div.sv
// Restoring divider, one quotient bit per cycle, 8-bit quotient.
`default_nettype none
module fdr_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [fdr_pkg::DVD_W-1:0] dividend,
  input  wire logic [fdr_pkg::DVS_W-1:0] divisor,
  output logic                           done,
  output logic [fdr_pkg::Q_W-1:0]        quot
);

  localparam int SD_W = fdr_pkg::DVS_W + fdr_pkg::Q_W - 1;
  localparam int CW   = $clog2(fdr_pkg::Q_W);

  logic [fdr_pkg::DVD_W-1:0] rem_r;
  logic [SD_W-1:0]           sd_r;
  logic [fdr_pkg::Q_W-1:0]   q_r;
  logic [CW-1:0]             cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic                      fits;

  assign fits = {{(fdr_pkg::DVD_W - SD_W){1'b0}}, sd_r} <= rem_r;

  // one compare-subtract a cycle, divisor shifted down
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= dividend;
        sd_r   <= {divisor, {(fdr_pkg::Q_W - 1){1'b0}}};
        cnt_r  <= CW'(fdr_pkg::Q_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (fits) begin
          rem_r <= rem_r - {{(fdr_pkg::DVD_W - SD_W){1'b0}}, sd_r};
        end
        q_r  <= {q_r[fdr_pkg::Q_W-2:0], fits};
        sd_r <= sd_r >> 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

FILE: hw/rtl/fdr_arith.sv
// Shared arithmetic unit: gamma power with rounding division, or plain division.
`default_nettype none
module fdr_arith (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire fdr_pkg::ar_op_t  op,
  input  wire logic [7:0]       v,
  input  wire logic [2:0]       e,
  input  wire logic [40:0]      dvd,
  input  wire logic [31:0]      dvs,
  output logic                  done,
  output logic [7:0]            res
);

  typedef enum logic [1:0] {
    A_IDLE,
    A_POW,
    A_DIV
  } ast_t;

  ast_t state_r;
  logic [fdr_pkg::NUM_W-1:0] num_r;
  logic [fdr_pkg::DEN_W-1:0] den_r;
  logic [7:0]                v_r;
  logic [2:0]                k_r;
  logic                      dv_start_r;
  logic [fdr_pkg::DVD_W-1:0] dv_n_r;
  logic [fdr_pkg::DVS_W-1:0] dv_d_r;
  logic                      dv_done;
  logic [fdr_pkg::Q_W-1:0]   dv_q;
  logic                      done_r;
  logic [7:0]                res_r;
  logic [fdr_pkg::NUM_W+7:0] prod;

  assign prod = num_r * v_r;

  fdr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start_r),
    .dividend (dv_n_r),
    .divisor  (dv_d_r),
    .done     (dv_done),
    .quot     (dv_q)
  );

  // sequencer: power loop, then divide for gamma; divide alone for AR_DIV
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= A_IDLE;
      dv_start_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      dv_start_r <= 1'b0;
      done_r     <= 1'b0;
      unique case (state_r)
        A_IDLE: begin
          if (start) begin
            if (op == fdr_pkg::AR_DIV) begin
              dv_n_r     <= fdr_pkg::DVD_W'(dvd);
              dv_d_r     <= fdr_pkg::DVS_W'(dvs);
              dv_start_r <= 1'b1;
              state_r    <= A_DIV;
            end else if (v == 8'd0) begin
              res_r  <= 8'd0;
              done_r <= 1'b1;
            end else if (v == 8'hFF || e == 3'd0) begin
              res_r  <= 8'hFF;
              done_r <= 1'b1;
            end else begin
              num_r   <= fdr_pkg::NUM_W'(v);
              den_r   <= fdr_pkg::DEN_W'(1);
              v_r     <= v;
              k_r     <= e - 3'd1;
              state_r <= A_POW;
            end
          end
        end
        A_POW: begin
          if (k_r == 3'd0) begin
            // round(num/den) = (2num + den) / (2den)
            dv_n_r     <= fdr_pkg::DVD_W'({num_r, 1'b0}) + fdr_pkg::DVD_W'(den_r);
            dv_d_r     <= {den_r, 1'b0};
            dv_start_r <= 1'b1;
            state_r    <= A_DIV;
          end else begin
            num_r <= prod[fdr_pkg::NUM_W-1:0];
            den_r <= {den_r[fdr_pkg::DEN_W-9:0], 8'd0} - den_r;
            k_r   <= k_r - 3'd1;
          end
        end
        A_DIV: begin
          if (dv_done) begin
            res_r   <= dv_q;
            done_r  <= 1'b1;
            state_r <= A_IDLE;
          end
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

FILE: hw/rtl/multichannel_gamma_led_fader_top.sv
// Start/stop/query scan every channel of the table; a start that claims a free channel
//   also runs the gamma of the port level when port_level_valid is set.
// Tick: inactive channels are passed over, active channels are worked in the shared
//   arithmetic unit (power loop plus 8-step divider, run twice on a fade step).
// One item at a time; results leave through a one-deep output register.
// Reset (synchronous, rst_n low) idles the sequencer; table entries read as reset values.
`default_nettype none
module multichannel_gamma_led_fader_top #(
  parameter int NUM_CHANNELS = fdr_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // pin, target_level, duration_ms, gamma_exp, use_default_gamma, port_level,
  // port_level_valid, now_ms
  input  wire logic [fdr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode
  input  wire logic [1:0]                      in_tuser,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // out_pin, write_valid, write_level, done_valid, done_level, ok, is_active,
  // current_level
  output logic [fdr_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tlast,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic [2:0]                      cfg_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready
);

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_CHANNELS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SC_RD,
    S_SC_EV,
    S_DEC,
    S_CLAIM,
    S_TK_SEL,
    S_TK_EV,
    S_TK_MUL,
    S_TK_DIV,
    S_TK_GAM,
    S_PUSH,
    S_FIN
  } st_t;

  st_t state_r;

  // item held for the whole walk
  logic [1:0]  mode_r;
  logic [7:0]  pin_r;
  logic [7:0]  tgt_r;
  logic [31:0] dur_r;
  logic [2:0]  g_r;
  logic [7:0]  port_r;
  logic        pv_r;
  logic [31:0] now_r;
  logic [2:0]  dgam_r;

  logic [AW-1:0]           idx_r;
  logic [NUM_CHANNELS-1:0] active_r;
  logic [NUM_CHANNELS-1:0] first_r;

  // scan results
  logic           hit_v_r;
  logic [AW-1:0]  hit_idx_r;
  fdr_pkg::chan_t hit_ent_r;
  logic           free_v_r;
  logic [AW-1:0]  free_idx_r;
  logic           seen_r;
  logic [7:0]     qcur_r;
  logic           qact_r;

  // tick work
  fdr_pkg::chan_t ent_r;
  logic           final_r;
  logic           fall_r;
  logic [39:0]    prod_r;

  // memory write port
  logic           wr_en_r;
  logic [AW-1:0]  wr_addr_r;
  fdr_pkg::chan_t wr_data_r;
  logic           rd_en;
  fdr_pkg::chan_t mem_rd;

  // arithmetic unit
  logic            ar_start_r;
  fdr_pkg::ar_op_t ar_op_r;
  logic [7:0]      ar_v_r;
  logic [2:0]      ar_e_r;
  logic [40:0]     ar_dvd_r;
  logic [31:0]     ar_dvs_r;
  logic            ar_done;
  logic [7:0]      ar_res;

  // results
  fdr_pkg::res_t res_r;
  fdr_pkg::res_t pend_r;
  logic          pend_v_r;
  fdr_pkg::res_t out_data_r;
  logic          out_valid_r;
  logic          out_last_r;

  logic          out_free;
  logic          match;
  logic [31:0]   el;
  logic          fall;
  logic [7:0]    lvl_dist;
  logic [7:0]    lin;

  assign out_free = !out_valid_r || out_tready;
  assign match    = mem_rd.pin == pin_r;
  assign el       = now_r - mem_rd.st;
  assign fall     = mem_rd.start > mem_rd.tgt;
  assign lvl_dist = fall ? (mem_rd.start - mem_rd.tgt) : (mem_rd.tgt - mem_rd.start);
  assign lin      = fall_r ? (ent_r.start - ar_res) : (ent_r.start + ar_res);
  assign rd_en    = (state_r == S_SC_RD) || (state_r == S_TK_SEL && active_r[idx_r]);

  fdr_mem #(
    .DEPTH (NUM_CHANNELS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (mem_rd),
    .wr_en   (wr_en_r),
    .wr_addr (wr_addr_r),
    .wr_data (wr_data_r)
  );

  fdr_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ar_start_r),
    .op    (ar_op_r),
    .v     (ar_v_r),
    .e     (ar_e_r),
    .dvd   (ar_dvd_r),
    .dvs   (ar_dvs_r),
    .done  (ar_done),
    .res   (ar_res)
  );

  // sequencer, table flags and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      first_r     <= '1;
      dgam_r      <= fdr_pkg::DEF_GAMMA;
      wr_en_r     <= 1'b0;
      ar_start_r  <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_en_r    <= 1'b0;
      ar_start_r <= 1'b0;
      if (cfg_valid) begin
        dgam_r <= cfg_data;
      end
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            mode_r   <= in_tuser;
            pin_r    <= in_tdata[7:0];
            tgt_r    <= in_tdata[15:8];
            dur_r    <= in_tdata[47:16];
            g_r      <= in_tdata[51] ? dgam_r : in_tdata[50:48];
            port_r   <= (in_tdata[67:60] != 8'd0) ? 8'hFF : in_tdata[59:52];
            pv_r     <= in_tdata[68];
            now_r    <= in_tdata[100:69];
            idx_r    <= '0;
            hit_v_r  <= 1'b0;
            free_v_r <= 1'b0;
            seen_r   <= 1'b0;
            qcur_r   <= 8'd0;
            qact_r   <= 1'b0;
            state_r  <= (in_tuser == fdr_pkg::MODE_TICK) ? S_TK_SEL : S_SC_RD;
          end
        end
        S_SC_RD: begin
          state_r <= S_SC_EV;
        end
        S_SC_EV: begin
          // first active match, first free channel, first holder of the pin
          if (active_r[idx_r] && match && !hit_v_r) begin
            hit_v_r   <= 1'b1;
            hit_idx_r <= idx_r;
            hit_ent_r <= mem_rd;
          end
          if (!active_r[idx_r] && !free_v_r) begin
            free_v_r   <= 1'b1;
            free_idx_r <= idx_r;
          end
          if (match && !seen_r) begin
            seen_r <= 1'b1;
            qcur_r <= mem_rd.cur;
          end
          if (match && active_r[idx_r]) begin
            qact_r <= 1'b1;
          end
          if (idx_r == LAST_IDX) begin
            state_r <= S_DEC;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SC_RD;
          end
        end
        S_DEC: begin
          res_r     <= '0;
          res_r.pin <= pin_r;
          state_r   <= S_PUSH;
          unique case (mode_r)
            fdr_pkg::MODE_START: begin
              if (hit_v_r) begin
                // re-target keeps the pin, restarts from the present level
                wr_en_r         <= 1'b1;
                wr_addr_r       <= hit_idx_r;
                wr_data_r       <= hit_ent_r;
                wr_data_r.start <= hit_ent_r.cur;
                wr_data_r.tgt   <= tgt_r;
                wr_data_r.dur   <= dur_r;
                wr_data_r.gam   <= g_r;
                wr_data_r.st    <= now_r;
                active_r[hit_idx_r] <= 1'b1;
                first_r[hit_idx_r]  <= 1'b1;
                res_r.ok <= 1'b1;
              end else if (free_v_r) begin
                if (pv_r) begin
                  ar_start_r <= 1'b1;
                  ar_op_r    <= fdr_pkg::AR_GAMMA;
                  ar_v_r     <= port_r;
                  ar_e_r     <= g_r;
                  state_r    <= S_CLAIM;
                end else begin
                  wr_en_r   <= 1'b1;
                  wr_addr_r <= free_idx_r;
                  wr_data_r <= '{gam: g_r, dur: dur_r, st: now_r, cur: 8'd0,
                                 start: 8'd0, tgt: tgt_r, pin: pin_r};
                  active_r[free_idx_r] <= 1'b1;
                  first_r[free_idx_r]  <= 1'b1;
                  res_r.ok <= 1'b1;
                end
              end
            end
            fdr_pkg::MODE_STOP: begin
              if (hit_v_r) begin
                active_r[hit_idx_r] <= 1'b0;
              end
              res_r.ok <= hit_v_r;
            end
            fdr_pkg::MODE_QUERY: begin
              res_r.act <= qact_r;
              res_r.cur <= qcur_r;
            end
            default: begin
              state_r <= S_FIN;
            end
          endcase
        end
        S_CLAIM: begin
          if (ar_done) begin
            wr_en_r   <= 1'b1;
            wr_addr_r <= free_idx_r;
            wr_data_r <= '{gam: g_r, dur: dur_r, st: now_r, cur: ar_res,
                           start: ar_res, tgt: tgt_r, pin: pin_r};
            active_r[free_idx_r] <= 1'b1;
            first_r[free_idx_r]  <= 1'b1;
            res_r.ok <= 1'b1;
            state_r  <= S_PUSH;
          end
        end
        S_TK_SEL: begin
          if (active_r[idx_r]) begin
            state_r <= S_TK_EV;
          end else if (idx_r == LAST_IDX) begin
            state_r <= S_FIN;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_TK_EV: begin
          ent_r <= mem_rd;
          if (first_r[idx_r]) begin
            // first tick restarts the clock and shows the start level
            first_r[idx_r] <= 1'b0;
            wr_en_r      <= 1'b1;
            wr_addr_r    <= idx_r;
            wr_data_r    <= mem_rd;
            wr_data_r.st <= now_r;
            res_r        <= '0;
            res_r.pin    <= mem_rd.pin;
            res_r.wv     <= 1'b1;
            res_r.wl     <= mem_rd.start;
            state_r      <= S_PUSH;
          end else if (el >= mem_rd.dur) begin
            active_r[idx_r] <= 1'b0;
            final_r    <= 1'b1;
            ar_start_r <= 1'b1;
            ar_op_r    <= fdr_pkg::AR_GAMMA;
            ar_v_r     <= mem_rd.tgt;
            ar_e_r     <= mem_rd.gam;
            state_r    <= S_TK_GAM;
          end else begin
            final_r <= 1'b0;
            fall_r  <= fall;
            prod_r  <= 40'(lvl_dist) * 40'(el);
            state_r <= S_TK_MUL;
          end
        end
        S_TK_MUL: begin
          // falling fades round the step up
          ar_start_r <= 1'b1;
          ar_op_r    <= fdr_pkg::AR_DIV;
          ar_dvd_r   <= {1'b0, prod_r} + (fall_r ? {9'd0, ent_r.dur - 32'd1} : 41'd0);
          ar_dvs_r   <= ent_r.dur;
          state_r    <= S_TK_DIV;
        end
        S_TK_DIV: begin
          if (ar_done) begin
            ar_start_r <= 1'b1;
            ar_op_r    <= fdr_pkg::AR_GAMMA;
            ar_v_r     <= lin;
            ar_e_r     <= ent_r.gam;
            state_r    <= S_TK_GAM;
          end
        end
        S_TK_GAM: begin
          if (ar_done) begin
            wr_addr_r     <= idx_r;
            wr_data_r     <= ent_r;
            wr_data_r.cur <= ar_res;
            res_r         <= '0;
            res_r.pin     <= ent_r.pin;
            if (ar_res != ent_r.cur) begin
              wr_en_r  <= 1'b1;
              res_r.wv <= 1'b1;
              res_r.wl <= ar_res;
            end
            if (final_r) begin
              res_r.dv <= 1'b1;
              res_r.dl <= ent_r.tgt;
              state_r  <= S_PUSH;
            end else if (ar_res != ent_r.cur) begin
              state_r <= S_PUSH;
            end else if (idx_r == LAST_IDX) begin
              state_r <= S_FIN;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_TK_SEL;
            end
          end
        end
        S_PUSH: begin
          // one result held back so the last one can be marked
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              out_data_r  <= pend_r;
              out_last_r  <= 1'b0;
              out_valid_r <= 1'b1;
            end
            pend_r   <= res_r;
            pend_v_r <= 1'b1;
            if (mode_r != fdr_pkg::MODE_TICK || idx_r == LAST_IDX) begin
              state_r <= S_FIN;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_TK_SEL;
            end
          end
        end
        S_FIN: begin
          if (!pend_v_r) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_data_r  <= pend_r;
            out_last_r  <= 1'b1;
            out_valid_r <= 1'b1;
            pend_v_r    <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{fdr_pkg::OUT_PAD{1'b0}}, out_data_r};

endmodule
`default_nettype wire

FILE: hw/rtl/fdr_chk.sv
// Port-level checker for the fader top, bound to every instance.
`default_nettype none
module fdr_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic [fdr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire logic                              out_tlast,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready
);

  // block works on one item: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // reset empties the output and opens the input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset did not idle the block");

  // level and done results never carry start/stop/query answers
  a_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[8] || out_tdata[17]) |-> !out_tdata[26] && !out_tdata[27])
    else $error("tick result mixed with command answer");

endmodule

bind multichannel_gamma_led_fader_top fdr_chk u_fdr_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
`default_nettype wire
